[hw/rtl/mpw_pkg.sv]
// Package for the max pooling window block: sizes, codes and shared types.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mpw_pkg;

    localparam int MAX_WIDTH    = 32;
    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_KERNEL   = 8;

    localparam int X_W     = 5;
    localparam int Y_W     = 5;
    localparam int CH_W    = 4;
    localparam int KS_W    = 4;
    localparam int MAP_W   = 6;
    localparam int VAL_W   = 16;
    localparam int CORN_W  = X_W + KS_W;
    localparam int CNT_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int ADDR_W  = CH_W + Y_W + X_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd3;

    localparam logic [KS_W-1:0]  KERNEL_SIZE_RST = 4'd2;
    localparam logic [KS_W-1:0]  STRIDE_RST      = 4'd2;
    localparam logic [MAP_W-1:0] MAP_WIDTH_RST   = 6'd32;
    localparam logic [MAP_W-1:0] MAP_HEIGHT_RST  = 6'd32;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [CH_W-1:0]         ch;
        logic [Y_W-1:0]          y;
        logic [X_W-1:0]          x;
        logic [KS_W-1:0]         k;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_flags_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_HOLD
    } bk_state_t;

    typedef struct packed {
        logic      pop;
        bk_state_t state;
    } bk_status_t;

endpackage

`default_nettype wire

[hw/rtl/mpw_front.sv]
// Front end of the max pooling window block: configuration registers, input
// transfers, window corner and bounds check. Depends on mpw_pkg.
`default_nettype none

module mpw_front
    import mpw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    input  wire fifo_flags_t           flags,
    output logic                       push,
    output cmd_t                       push_cmd
);

    logic [KS_W-1:0]   kernel_size_reg;
    logic [KS_W-1:0]   stride_reg;
    logic [MAP_W-1:0]  map_width_reg;
    logic [MAP_W-1:0]  map_height_reg;

    logic [X_W-1:0]    px;
    logic [Y_W-1:0]    py;
    logic [CH_W-1:0]   ch;
    logic [VAL_W-1:0]  val;
    logic [MAP_W-1:0]  mw_eff;
    logic [MAP_W-1:0]  mh_eff;
    logic [CORN_W-1:0] x0;
    logic [CORN_W-1:0] y0;
    logic [CORN_W:0]   x_end;
    logic [CORN_W:0]   y_end;
    logic              win_err;
    logic              write_ok;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg <= KERNEL_SIZE_RST;
            stride_reg      <= STRIDE_RST;
            map_width_reg   <= MAP_WIDTH_RST;
            map_height_reg  <= MAP_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_KERNEL_SIZE: kernel_size_reg <= cfg_wdata[KS_W-1:0];
                CFG_STRIDE:      stride_reg      <= cfg_wdata[KS_W-1:0];
                CFG_MAP_WIDTH:   map_width_reg   <= cfg_wdata[MAP_W-1:0];
                CFG_MAP_HEIGHT:  map_height_reg  <= cfg_wdata[MAP_W-1:0];
            endcase
        end
    end

    assign px  = s_axis_tdata[X_W-1:0];
    assign py  = s_axis_tdata[X_W+Y_W-1:X_W];
    assign ch  = s_axis_tdata[X_W+Y_W+CH_W-1:X_W+Y_W];
    assign val = s_axis_tdata[X_W+Y_W+CH_W+VAL_W-1:X_W+Y_W+CH_W];

    assign s_axis_tready = !flags.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        mw_eff = (int'(map_width_reg) > MAX_WIDTH) ? MAP_W'(MAX_WIDTH) : map_width_reg;
        mh_eff = (int'(map_height_reg) > MAX_HEIGHT) ? MAP_W'(MAX_HEIGHT) : map_height_reg;
        x0     = CORN_W'(px) * CORN_W'(stride_reg);
        y0     = CORN_W'(py) * CORN_W'(stride_reg);
        x_end  = (CORN_W+1)'(x0) + (CORN_W+1)'(kernel_size_reg);
        y_end  = (CORN_W+1)'(y0) + (CORN_W+1)'(kernel_size_reg);
        win_err = (kernel_size_reg == '0) ||
                  (int'(kernel_size_reg) > MAX_KERNEL) ||
                  (int'(ch) >= MAX_CHANNELS) ||
                  (x_end > (CORN_W+1)'(mw_eff)) ||
                  (y_end > (CORN_W+1)'(mh_eff));
        write_ok = (int'(px) < MAX_WIDTH) && (int'(py) < MAX_HEIGHT) &&
                   (int'(ch) < MAX_CHANNELS);
    end

    always_comb
    begin
        push_cmd.ch    = ch;
        push_cmd.k     = kernel_size_reg;
        push_cmd.value = val;
        if (s_axis_tuser == REQ_WRITE)
        begin
            push_cmd.kind = CMD_WRITE;
            push_cmd.x    = px;
            push_cmd.y    = py;
        end
        else
        begin
            push_cmd.kind = win_err ? CMD_ERROR : CMD_QUERY;
            push_cmd.x    = x0[X_W-1:0];
            push_cmd.y    = y0[Y_W-1:0];
        end
        push = accept && ((s_axis_tuser == REQ_QUERY) || write_ok);
    end

endmodule

`default_nettype wire

[hw/rtl/mpw_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on mpw_pkg for the command type and depth.
`default_nettype none

module mpw_cmd_fifo
    import mpw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    input  wire logic  pop,
    output cmd_t       head_cmd,
    output fifo_flags_t flags
);

    cmd_t               entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign flags.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head_cmd    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mpw_back.sv]
// Back end of the max pooling window block: feature store, window scan and
// the result register. Depends on mpw_pkg.
`default_nettype none

module mpw_back
    import mpw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   head_cmd,
    input  wire fifo_flags_t            flags,
    output bk_status_t                  status,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                        m_axis_tuser
);

    logic [VAL_W-1:0]        store_mem [STORE_DEPTH];

    bk_state_t               state_reg;
    bk_state_t               state_next;
    cmd_t                    cmd_reg;
    logic [CNT_W-1:0]        cnt_x_reg;
    logic [CNT_W-1:0]        cnt_y_reg;
    logic                    rd_valid_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic signed [VAL_W-1:0] best_reg;
    logic                    out_valid_reg;
    logic [VAL_W-1:0]        out_data_reg;
    logic                    out_err_reg;

    logic                    out_free;
    logic                    pop;
    logic                    start;
    logic                    mem_we;
    logic                    rd_en;
    logic                    load_err;
    logic                    load_best;
    logic                    x_last;
    logic                    y_last;
    logic                    scan_last;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [X_W-1:0]          rd_x;
    logic [Y_W-1:0]          rd_y;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign x_last    = (KS_W'(cnt_x_reg) == cmd_reg.k - 1'b1);
    assign y_last    = (KS_W'(cnt_y_reg) == cmd_reg.k - 1'b1);
    assign scan_last = x_last && y_last;
    assign rd_x      = cmd_reg.x + X_W'(cnt_x_reg);
    assign rd_y      = cmd_reg.y + Y_W'(cnt_y_reg);
    assign rd_addr   = {cmd_reg.ch, rd_y, rd_x};
    assign wr_addr   = {head_cmd.ch, head_cmd.y, head_cmd.x};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!flags.empty && (head_cmd.kind == CMD_QUERY))
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        start     = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        load_err  = 1'b0;
        load_best = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!flags.empty)
                begin
                    unique case (head_cmd.kind)
                        CMD_WRITE:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            pop   = 1'b1;
                            start = 1'b1;
                        end
                        CMD_ERROR:
                        begin
                            pop      = out_free;
                            load_err = out_free;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                rd_en = 1'b1;
            end
            BK_DRAIN:
            begin
            end
            BK_HOLD:
            begin
                load_best = out_free;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_x_reg     <= '0;
            cnt_y_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (load_err || load_best)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (start)
            begin
                cnt_x_reg <= '0;
                cnt_y_reg <= '0;
            end
            else if (rd_en)
            begin
                if (x_last)
                begin
                    cnt_x_reg <= '0;
                    cnt_y_reg <= cnt_y_reg + 1'b1;
                end
                else
                begin
                    cnt_x_reg <= cnt_x_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg  <= head_cmd;
            best_reg <= VAL_MIN;
        end
        else if (rd_valid_reg && (rd_data_reg > best_reg))
        begin
            best_reg <= rd_data_reg;
        end
        if (load_err)
        begin
            out_data_reg <= '0;
            out_err_reg  <= 1'b1;
        end
        else if (load_best)
        begin
            out_data_reg <= best_reg;
            out_err_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= head_cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign status.pop    = pop;
    assign status.state  = state_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

`default_nettype wire

[hw/rtl/max_pool_window.sv]
// Top level of the max pooling window block: front end, command queue and
// back end. Depends on mpw_pkg, mpw_front, mpw_cmd_fifo and mpw_back.
//
// Channel  Direction  Contents
// s_axis   in         tuser: req_type; tdata: pos_x, pos_y, channel, value
// m_axis   out        tuser: window_error; tdata: max_value
// cfg      in         cfg_we, cfg_addr (register index), cfg_wdata
//
// In the back end a write is stored from the idle state; a window query goes
// through the scan, drain and hold states, reading via the single read port
// of the feature store; an out-of-map query loads its error result from idle.
// Reset restores the default configuration; the feature store is not cleared.
// A two-entry queue lets input transfers continue while a result waits.
`default_nettype none

module max_pool_window
    import mpw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_x[4:0], pos_y[9:5], channel[13:10], value[29:14], zero[31:30]
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[0]
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // max_value[15:0]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // window_error[0]
    output logic                        m_axis_tuser
);

    fifo_flags_t flags;
    bk_status_t  status;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        push;

    mpw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .flags         (flags),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    mpw_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (status.pop),
        .head_cmd (head_cmd),
        .flags    (flags)
    );

    mpw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .flags         (flags),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> !flags.empty)
        else $error("Command popped from an empty queue.");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("Window error result carries nonzero data.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(status.state == BK_HOLD || status.state == BK_IDLE))
        else $error("Result appeared outside the idle or hold state.");

    a_drain_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (status.state == BK_DRAIN) |=> (status.state == BK_HOLD))
        else $error("Scan drain did not move to hold.");

endmodule

`default_nettype wire

[tb/sv/tb_max_pool_window.sv]
`timescale 1ns / 1ps
// Self-checking testbench for max_pool_window: loads feature map elements, pools windows
// under a range of register settings and compares every result with its own model.
// Depends on mpw_pkg and the max_pool_window RTL.
module tb_max_pool_window;
    import mpw_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int POS_TOP       = (1 << X_W) - 1;

    typedef struct packed {
        logic [VAL_W-1:0] max_value;
        logic             window_error;
    } pooled_t;

    class pool_scoreboard;
        logic signed [VAL_W-1:0] fmap [STORE_DEPTH];
        logic [KS_W-1:0]  ks_r     = KERNEL_SIZE_RST;
        logic [KS_W-1:0]  stride_r = STRIDE_RST;
        logic [MAP_W-1:0] cols_r   = MAP_WIDTH_RST;
        logic [MAP_W-1:0] rows_r   = MAP_HEIGHT_RST;
        pooled_t pooled_due [$];
        int mismatches = 0;
        int checked    = 0;
        int writes     = 0;
        int queries    = 0;
        int errors     = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KERNEL_SIZE: ks_r     = data[KS_W-1:0];
                CFG_STRIDE:      stride_r = data[KS_W-1:0];
                CFG_MAP_WIDTH:   cols_r   = data[MAP_W-1:0];
                CFG_MAP_HEIGHT:  rows_r   = data[MAP_W-1:0];
                default: ;
            endcase
        endfunction

        function pooled_t predict_pool(logic [X_W-1:0] px, logic [Y_W-1:0] py,
                                       logic [CH_W-1:0] ch);
            int eff_w;
            int eff_h;
            int x0;
            int y0;
            int k;
            logic signed [VAL_W-1:0] elem;
            logic signed [VAL_W-1:0] best;
            pooled_t r;
            k     = int'(ks_r);
            eff_w = (int'(cols_r) > MAX_WIDTH) ? MAX_WIDTH : int'(cols_r);
            eff_h = (int'(rows_r) > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_r);
            x0    = int'(px) * int'(stride_r);
            y0    = int'(py) * int'(stride_r);
            if (k == 0 || k > MAX_KERNEL || int'(ch) >= MAX_CHANNELS ||
                x0 + k > eff_w || y0 + k > eff_h) begin
                r.max_value    = '0;
                r.window_error = 1'b1;
                return r;
            end
            best = VAL_MIN;
            for (int i = 0; i < k; i++)
                for (int j = 0; j < k; j++) begin
                    elem = fmap[(int'(ch) * MAX_HEIGHT + y0 + j) * MAX_WIDTH + x0 + i];
                    if (elem > best)
                        best = elem;
                end
            r.max_value    = best;
            r.window_error = 1'b0;
            return r;
        endfunction

        function void take_request(logic req, logic [IN_DATA_W-1:0] data);
            logic [X_W-1:0]  px;
            logic [Y_W-1:0]  py;
            logic [CH_W-1:0] ch;
            pooled_t want;
            px = data[X_W-1:0];
            py = data[X_W +: Y_W];
            ch = data[X_W+Y_W +: CH_W];
            if (req == REQ_WRITE) begin
                fmap[{ch, py, px}] = data[X_W+Y_W+CH_W +: VAL_W];
                writes++;
            end
            else begin
                want = predict_pool(px, py, ch);
                pooled_due.push_back(want);
                queries++;
                if (want.window_error)
                    errors++;
            end
        endfunction

        function void report_fault(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        function void check_pooled(logic [OUT_DATA_W-1:0] data, logic err);
            pooled_t want;
            if (pooled_due.size() == 0) begin
                report_fault($sformatf("unexpected result max_value=%0d window_error=%0b",
                                       $signed(data), err));
                return;
            end
            want = pooled_due.pop_front();
            checked++;
            if (data !== want.max_value)
                report_fault($sformatf("result %0d max_value: expected %0d, got %0d",
                                       checked, $signed(want.max_value), $signed(data)));
            if (err !== want.window_error)
                report_fault($sformatf("result %0d window_error: expected %0b, got %0b",
                                       checked, want.window_error, err));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    pool_scoreboard sb = new();
    bit filled [STORE_DEPTH];
    int cur_k = 2;
    int cur_s = 2;
    int cur_w = 32;
    int cur_h = 32;
    int sent = 0;
    int settings = 1;
    int tx_calm = 0;
    int rx_calm = 0;
    bit hold_request = 1'b0;

    max_pool_window dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pooled(m_axis_tdata, m_axis_tuser);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Idle gaps are drawn at random, with occasional stretches of back-to-back transfers.
    function automatic int draw_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return 16'h7FFF;
            2:       return VAL_W'($urandom_range(0, 7)) - VAL_W'(4);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(input logic req, input int x, input int y, input int ch,
                             input logic [VAL_W-1:0] val);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, val, ch[CH_W-1:0], y[Y_W-1:0], x[X_W-1:0]};
        do @(posedge clk); while (!s_axis_tready);
        if (req == REQ_WRITE)
            filled[(ch * MAX_HEIGHT + y) * MAX_WIDTH + x] = 1'b1;
        sent++;
    endtask

    // Every element of an in-map window is written before the window is read.
    task automatic window_query(input int px, input int py, input int ch, input bit refresh);
        int eff_w;
        int eff_h;
        int x0;
        int y0;
        int addr;
        eff_w = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
        eff_h = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
        x0 = px * cur_s;
        y0 = py * cur_s;
        if (cur_k >= 1 && cur_k <= MAX_KERNEL && x0 + cur_k <= eff_w && y0 + cur_k <= eff_h)
            for (int i = 0; i < cur_k; i++)
                for (int j = 0; j < cur_k; j++)
                begin
                    addr = (ch * MAX_HEIGHT + y0 + j) * MAX_WIDTH + x0 + i;
                    if (!filled[addr] || (refresh && $urandom_range(0, 3) == 0))
                        send_item(REQ_WRITE, x0 + i, y0 + j, ch, rand_value());
                end
        send_item(REQ_QUERY, px, py, ch, VAL_W'($urandom));
    endtask

    task automatic pool_sequence();
        int eff_w;
        int eff_h;
        int ch;
        int px;
        int py;
        int px_max;
        int py_max;
        eff_w = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
        eff_h = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
        ch = $urandom_range(0, MAX_CHANNELS - 1);
        px = $urandom_range(0, POS_TOP);
        py = $urandom_range(0, POS_TOP);
        if (cur_k >= 1 && cur_k <= MAX_KERNEL && cur_k <= eff_w && cur_k <= eff_h &&
            cur_s > 0)
        begin
            px_max = (eff_w - cur_k) / cur_s;
            py_max = (eff_h - cur_k) / cur_s;
            if (px_max > POS_TOP)
                px_max = POS_TOP;
            if (py_max > POS_TOP)
                py_max = POS_TOP;
            px = $urandom_range(0, px_max);
            py = $urandom_range(0, py_max);
            // Step just past the map edge now and then.
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    px = (px_max < POS_TOP) ? px_max + 1 : px_max;
                else
                    py = (py_max < POS_TOP) ? py_max + 1 : py_max;
            end
        end
        window_query(px, py, ch, 1'b1);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(data);
        sb.set_reg(idx, CFG_DATA_W'(data));
        @(posedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pooled_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int k, input int s, input int w, input int h,
                             input int budget, input bit hold);
        int first;
        settle();
        put_reg(CFG_KERNEL_SIZE, k);
        put_reg(CFG_STRIDE, s);
        put_reg(CFG_MAP_WIDTH, w);
        put_reg(CFG_MAP_HEIGHT, h);
        cfg_we <= 1'b0;
        cur_k = k;
        cur_s = s;
        cur_w = w;
        cur_h = h;
        settings++;
        if (hold)
            hold_request = 1'b1;
        first = sent;
        while (sent - first < budget)
            case ($urandom_range(0, 9))
                0: send_item(REQ_WRITE, $urandom_range(0, POS_TOP), $urandom_range(0, POS_TOP),
                             $urandom_range(0, MAX_CHANNELS - 1), rand_value());
                1: window_query($urandom_range(0, POS_TOP), $urandom_range(0, POS_TOP),
                                $urandom_range(0, MAX_CHANNELS - 1), 1'b0);
                default: pool_sequence();
            endcase
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-minimum window, then one maximum element, on the default 2x2 setting.
        for (int i = 0; i < 4; i++)
            send_item(REQ_WRITE, i % 2, i / 2, 0, VAL_MIN);
        send_item(REQ_QUERY, 0, 0, 0, '0);
        send_item(REQ_WRITE, 1, 1, 0, 16'h7FFF);
        send_item(REQ_QUERY, 0, 0, 0, '0);
        // Far corner of the store on the last channel, mixed signs.
        send_item(REQ_WRITE, 30, 30, 15, 16'h0000);
        send_item(REQ_WRITE, 31, 30, 15, 16'hFFFF);
        send_item(REQ_WRITE, 30, 31, 15, 16'h0100);
        send_item(REQ_WRITE, 31, 31, 15, 16'h00FF);
        send_item(REQ_QUERY, 15, 15, 15, 16'hFFFF);
        // Windows that leave the map.
        send_item(REQ_QUERY, 16, 0, 0, '0);
        send_item(REQ_QUERY, 0, 31, 3, '0);
        send_item(REQ_QUERY, 31, 31, 15, '0);

        run_phase(2, 2, 32, 32, 50, 1'b0);
        run_phase(1, 1, 32, 32, 60, 1'b1);
        run_phase(8, 8, 32, 32, 50, 1'b0);
        run_phase(3, 0, 32, 32, 50, 1'b0);
        run_phase(0, 1, 32, 32, 30, 1'b0);
        run_phase(9, 1, 32, 32, 30, 1'b0);
        run_phase(15, 15, 63, 63, 40, 1'b0);
        run_phase(4, 3, 33, 20, 60, 1'b0);
        run_phase(2, 1, 0, 0, 30, 1'b0);
        run_phase(1, 15, 1, 1, 50, 1'b0);
        run_phase(5, 2, 17, 9, 60, 1'b0);
        run_phase(8, 1, 8, 8, 60, 1'b0);
        run_phase(1, 1, 32, 32, 80, 1'b0);
        run_phase(2, 2, 32, 32, 60, 1'b0);
        settle();

        $display("Checked %0d pooled results (%0d window errors) from %0d writes and %0d queries.",
                 sb.checked, sb.errors, sb.writes, sb.queries);
        $display("Covered %0d register settings, including zero stride, bad kernels, %s",
                 settings, "empty and oversized maps, and a long output stall.");
        if (sb.mismatches == 0 && sb.pooled_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
